// ----- rtl/nfcs_pkg.sv -----
// Shared types, codes and flash command constants for the NOR flash command sequencer.
package nfcs_pkg;

  localparam int ADDR_W = 19;
  localparam int DATA_W = 8;
  localparam int KIND_W = 3;
  localparam int CK_W   = 2;
  localparam int ST_W   = 2;
  localparam int SZ_W   = 2;
  localparam int OP_W   = 3;
  localparam int STEP_W = 3;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [DATA_W-1:0] byte_t;
  typedef logic [KIND_W-1:0] kind_t;
  typedef logic [CK_W-1:0]   cyc_kind_t;
  typedef logic [ST_W-1:0]   status_t;
  typedef logic [SZ_W-1:0]   size_t;
  typedef logic [OP_W-1:0]   op_t;
  typedef logic [STEP_W-1:0] step_t;

  // input item kinds
  localparam kind_t KIND_IDENT        = 3'd0;
  localparam kind_t KIND_ERASE_CHIP   = 3'd1;
  localparam kind_t KIND_ERASE_SECTOR = 3'd2;
  localparam kind_t KIND_PROGRAM      = 3'd3;
  localparam kind_t KIND_READ_DATA    = 3'd4;

  // result cycle kinds
  localparam cyc_kind_t CK_WRITE = 2'd0;
  localparam cyc_kind_t CK_READ  = 2'd1;
  localparam cyc_kind_t CK_DONE  = 2'd2;

  // finish status
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_BAD_MAKER = 2'd1;
  localparam status_t ST_BUSY      = 2'd2;

  // size codes
  localparam size_t SZ_UNKNOWN = 2'd0;
  localparam size_t SZ_128K    = 2'd1;
  localparam size_t SZ_256K    = 2'd2;
  localparam size_t SZ_512K    = 2'd3;

  // bus addresses
  localparam addr_t ADDR_UNLOCK1 = 19'h05555;
  localparam addr_t ADDR_UNLOCK2 = 19'h02AAA;
  localparam addr_t ADDR_MAKER   = 19'h00000;
  localparam addr_t ADDR_DEVICE  = 19'h00001;

  // command bytes
  localparam byte_t CMD_UNLOCK1      = 8'hAA;
  localparam byte_t CMD_UNLOCK2      = 8'h55;
  localparam byte_t CMD_ID_ENTRY     = 8'h90;
  localparam byte_t CMD_ERASE_SETUP  = 8'h80;
  localparam byte_t CMD_CHIP_ERASE   = 8'h10;
  localparam byte_t CMD_SECTOR_ERASE = 8'h30;
  localparam byte_t CMD_PROGRAM      = 8'hA0;
  localparam byte_t CMD_ID_EXIT      = 8'hF0;

  localparam byte_t MAKER_EXPECTED = 8'hBF;
  localparam byte_t DEV_128K       = 8'hB5;
  localparam byte_t DEV_256K       = 8'hB6;
  localparam byte_t DEV_512K       = 8'hB7;
  localparam int    TOGGLE_BIT     = 6;

  // jobs passed from the front to the back
  localparam op_t OP_IDENT   = 3'd0;
  localparam op_t OP_ERASE   = 3'd1;
  localparam op_t OP_PROGRAM = 3'd2;
  localparam op_t OP_READ    = 3'd3;
  localparam op_t OP_ID_DONE = 3'd4;
  localparam op_t OP_DONE    = 3'd5;

  typedef struct packed {
    op_t     op;
    addr_t   addr;
    byte_t   data;    // command byte, program byte or device ID
    status_t status;
    size_t   size;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } q2b_t;

  typedef struct packed {
    cyc_kind_t cycle_kind;
    addr_t     bus_address;
    byte_t     bus_data;
    status_t   status;
    byte_t     part_id;
    size_t     size_code;
    logic      last;
  } res_t;

endpackage

// ----- rtl/nfcs_if.sv -----
// Command and result channel interfaces of the NOR flash command sequencer.
interface nfcs_cmd_if;
  logic            valid;
  logic            ready;
  nfcs_pkg::kind_t kind;
  nfcs_pkg::addr_t address;
  nfcs_pkg::byte_t data;

  modport source (output valid, kind, address, data, input ready);
  modport sink (input valid, kind, address, data, output ready);
endinterface

interface nfcs_res_if;
  logic                valid;
  logic                ready;
  nfcs_pkg::cyc_kind_t cycle_kind;
  nfcs_pkg::addr_t     bus_address;
  nfcs_pkg::byte_t     bus_data;
  nfcs_pkg::status_t   status;
  nfcs_pkg::byte_t     part_id;
  nfcs_pkg::size_t     size_code;
  logic                last;

  modport source (output valid, cycle_kind, bus_address, bus_data, status, part_id,
                  size_code, last, input ready);
  modport sink (input valid, cycle_kind, bus_address, bus_data, status, part_id,
                size_code, last, output ready);
endinterface

// ----- rtl/nfcs_front.sv -----
// Front end: accepts commands and read data, tracks the command phase, issues jobs.
module nfcs_front (
  input  logic            clk,
  input  logic            rst_n,
  nfcs_cmd_if.sink        cmd,
  input  logic            full_i,
  output logic            push_o,
  output nfcs_pkg::job_t  job_o
);

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_MAKER  = 2'd1;
  localparam logic [1:0] PH_DEVICE = 2'd2;
  localparam logic [1:0] PH_POLL   = 2'd3;

  logic [1:0]      phase_r, phase_nxt;
  nfcs_pkg::addr_t poll_address_r, poll_address_nxt;
  logic            last_toggle_bit_r, last_toggle_bit_nxt;
  logic            first_poll_pending_r, first_poll_pending_nxt;
  nfcs_pkg::byte_t maker_id_r, maker_id_nxt;

  logic            accept;
  logic            push_c;
  nfcs_pkg::job_t  job_c;
  nfcs_pkg::size_t size_c;
  logic            tbit;

  assign cmd.ready = !full_i;
  assign accept    = cmd.valid && !full_i;
  assign tbit      = cmd.data[nfcs_pkg::TOGGLE_BIT];

  always_comb begin
    unique case (cmd.data)
      nfcs_pkg::DEV_128K: size_c = nfcs_pkg::SZ_128K;
      nfcs_pkg::DEV_256K: size_c = nfcs_pkg::SZ_256K;
      nfcs_pkg::DEV_512K: size_c = nfcs_pkg::SZ_512K;
      default:            size_c = nfcs_pkg::SZ_UNKNOWN;
    endcase
  end

  always_comb begin
    phase_nxt              = phase_r;
    poll_address_nxt       = poll_address_r;
    last_toggle_bit_nxt    = last_toggle_bit_r;
    first_poll_pending_nxt = first_poll_pending_r;
    maker_id_nxt           = maker_id_r;
    push_c                 = 1'b0;
    job_c                  = '0;
    if (accept) begin
      if (cmd.kind <= nfcs_pkg::KIND_PROGRAM && phase_r != PH_IDLE) begin
        // reject while busy, leave the state alone
        push_c       = 1'b1;
        job_c.op     = nfcs_pkg::OP_DONE;
        job_c.status = nfcs_pkg::ST_BUSY;
      end else begin
        unique case (cmd.kind) inside
          nfcs_pkg::KIND_IDENT: begin
            push_c    = 1'b1;
            job_c.op  = nfcs_pkg::OP_IDENT;
            phase_nxt = PH_MAKER;
          end
          nfcs_pkg::KIND_ERASE_CHIP, nfcs_pkg::KIND_ERASE_SECTOR: begin
            push_c     = 1'b1;
            job_c.op   = nfcs_pkg::OP_ERASE;
            job_c.addr = (cmd.kind == nfcs_pkg::KIND_ERASE_CHIP) ?
                         nfcs_pkg::ADDR_UNLOCK1 : cmd.address;
            job_c.data = (cmd.kind == nfcs_pkg::KIND_ERASE_CHIP) ?
                         nfcs_pkg::CMD_CHIP_ERASE : nfcs_pkg::CMD_SECTOR_ERASE;
            poll_address_nxt       = job_c.addr;
            first_poll_pending_nxt = 1'b1;
            last_toggle_bit_nxt    = 1'b0;
            phase_nxt              = PH_POLL;
          end
          nfcs_pkg::KIND_PROGRAM: begin
            push_c                 = 1'b1;
            job_c.op               = nfcs_pkg::OP_PROGRAM;
            job_c.addr             = cmd.address;
            job_c.data             = cmd.data;
            poll_address_nxt       = cmd.address;
            first_poll_pending_nxt = 1'b1;
            last_toggle_bit_nxt    = 1'b0;
            phase_nxt              = PH_POLL;
          end
          nfcs_pkg::KIND_READ_DATA: begin
            unique case (phase_r)
              PH_MAKER: begin
                maker_id_nxt = cmd.data;
                push_c       = 1'b1;
                job_c.op     = nfcs_pkg::OP_READ;
                job_c.addr   = nfcs_pkg::ADDR_DEVICE;
                phase_nxt    = PH_DEVICE;
              end
              PH_DEVICE: begin
                push_c    = 1'b1;
                job_c.op  = nfcs_pkg::OP_ID_DONE;
                phase_nxt = PH_IDLE;
                if (maker_id_r != nfcs_pkg::MAKER_EXPECTED) begin
                  job_c.status = nfcs_pkg::ST_BAD_MAKER;
                end else begin
                  job_c.data = cmd.data;
                  job_c.size = size_c;
                end
              end
              PH_POLL: begin
                push_c = 1'b1;
                if (first_poll_pending_r || tbit != last_toggle_bit_r) begin
                  first_poll_pending_nxt = 1'b0;
                  last_toggle_bit_nxt    = tbit;
                  job_c.op               = nfcs_pkg::OP_READ;
                  job_c.addr             = poll_address_r;
                end else begin
                  job_c.op  = nfcs_pkg::OP_DONE;
                  phase_nxt = PH_IDLE;
                end
              end
              default: ;
            endcase
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r              <= PH_IDLE;
      poll_address_r       <= '0;
      last_toggle_bit_r    <= 1'b0;
      first_poll_pending_r <= 1'b0;
      maker_id_r           <= '0;
    end else begin
      phase_r              <= phase_nxt;
      poll_address_r       <= poll_address_nxt;
      last_toggle_bit_r    <= last_toggle_bit_nxt;
      first_poll_pending_r <= first_poll_pending_nxt;
      maker_id_r           <= maker_id_nxt;
    end
  end

  assign push_o = push_c;
  assign job_o  = job_c;

`ifndef SYNTHESIS
  a_first_poll_in_poll: assert property (@(posedge clk) disable iff (!rst_n)
    first_poll_pending_r |-> phase_r == PH_POLL)
    else $error("first poll pending outside the polling phase");
`endif

endmodule

// ----- rtl/nfcs_queue.sv -----
// Job queue between the front end and the bus cycle sequencer.
module nfcs_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_i,
  input  nfcs_pkg::job_t job_i,
  output logic           full_o,
  output nfcs_pkg::q2b_t head_o,
  input  logic           pop_i
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  nfcs_pkg::job_t   mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full_o       = (count_r == CNT_W'(DEPTH));
  assign head_o.valid = (count_r != '0);
  assign head_o.job   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= job_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_r + CNT_W'(push_i) - CNT_W'(pop_i);
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push_i |-> !full_o)
    else $error("job pushed into a full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop_i |-> count_r != '0)
    else $error("job popped from an empty queue");
  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> count_r == $past(count_r) + CNT_W'($past(push_i))
                               - CNT_W'($past(pop_i)))
    else $error("queue fill count out of step with transfers");
`endif

endmodule

// ----- rtl/nfcs_back.sv -----
// Back end: expands each job into its bus cycles and finish result, one per clock unless the result channel stalls.
module nfcs_back (
  input  logic            clk,
  input  logic            rst_n,
  input  nfcs_pkg::q2b_t  head_i,
  output logic            pop_o,
  nfcs_res_if.source      res
);

  nfcs_pkg::step_t step_r;
  nfcs_pkg::res_t  res_r;
  logic            res_valid_r;
  nfcs_pkg::res_t  item;
  logic            advance;

  function automatic nfcs_pkg::res_t wr_item(nfcs_pkg::addr_t a, nfcs_pkg::byte_t d);
    nfcs_pkg::res_t r;
    r             = '0;
    r.cycle_kind  = nfcs_pkg::CK_WRITE;
    r.bus_address = a;
    r.bus_data    = d;
    return r;
  endfunction

  function automatic nfcs_pkg::res_t rd_item(nfcs_pkg::addr_t a);
    nfcs_pkg::res_t r;
    r             = '0;
    r.cycle_kind  = nfcs_pkg::CK_READ;
    r.bus_address = a;
    r.last        = 1'b1;
    return r;
  endfunction

  function automatic nfcs_pkg::res_t unlock_item(nfcs_pkg::step_t s);
    nfcs_pkg::res_t r;
    r = s[0] ? wr_item(nfcs_pkg::ADDR_UNLOCK2, nfcs_pkg::CMD_UNLOCK2)
             : wr_item(nfcs_pkg::ADDR_UNLOCK1, nfcs_pkg::CMD_UNLOCK1);
    return r;
  endfunction

  // result for the current step of the job at the queue head
  always_comb begin
    item = '0;
    unique case (head_i.job.op) inside
      nfcs_pkg::OP_IDENT: begin
        unique case (step_r) inside
          3'd0, 3'd1: item = unlock_item(step_r);
          3'd2:       item = wr_item(nfcs_pkg::ADDR_UNLOCK1, nfcs_pkg::CMD_ID_ENTRY);
          default:    item = rd_item(nfcs_pkg::ADDR_MAKER);
        endcase
      end
      nfcs_pkg::OP_ERASE: begin
        unique case (step_r) inside
          3'd0, 3'd1: item = unlock_item(step_r);
          3'd2:       item = wr_item(nfcs_pkg::ADDR_UNLOCK1, nfcs_pkg::CMD_ERASE_SETUP);
          3'd3:       item = unlock_item(3'd0);
          3'd4:       item = unlock_item(3'd1);
          3'd5:       item = wr_item(head_i.job.addr, head_i.job.data);
          default:    item = rd_item(head_i.job.addr);
        endcase
      end
      nfcs_pkg::OP_PROGRAM: begin
        unique case (step_r) inside
          3'd0, 3'd1: item = unlock_item(step_r);
          3'd2:       item = wr_item(nfcs_pkg::ADDR_UNLOCK1, nfcs_pkg::CMD_PROGRAM);
          3'd3:       item = wr_item(head_i.job.addr, head_i.job.data);
          default:    item = rd_item(head_i.job.addr);
        endcase
      end
      nfcs_pkg::OP_READ: item = rd_item(head_i.job.addr);
      nfcs_pkg::OP_ID_DONE, nfcs_pkg::OP_DONE: begin
        if (head_i.job.op == nfcs_pkg::OP_ID_DONE && step_r == '0) begin
          item = wr_item(nfcs_pkg::ADDR_UNLOCK1, nfcs_pkg::CMD_ID_EXIT);
        end else begin
          item.cycle_kind = nfcs_pkg::CK_DONE;
          item.status     = head_i.job.status;
          item.part_id    = head_i.job.data;
          item.size_code  = head_i.job.size;
          item.last       = 1'b1;
        end
      end
      default: item = '0;
    endcase
  end

  // load the output register when a job is waiting and the register is empty or being drained
  assign advance = head_i.valid && (!res_valid_r || res.ready);
  assign pop_o   = advance && item.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
      step_r      <= '0;
    end else if (advance) begin
      res_valid_r <= 1'b1;
      step_r      <= item.last ? '0 : step_r + 3'd1;
    end else if (res.ready) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= item;
    end
  end

  assign res.valid       = res_valid_r;
  assign res.cycle_kind  = res_r.cycle_kind;
  assign res.bus_address = res_r.bus_address;
  assign res.bus_data    = res_r.bus_data;
  assign res.status      = res_r.status;
  assign res.part_id     = res_r.part_id;
  assign res.size_code   = res_r.size_code;
  assign res.last        = res_r.last;

`ifndef SYNTHESIS
  a_job_held_mid_sequence: assert property (@(posedge clk) disable iff (!rst_n)
    step_r != '0 |-> head_i.valid)
    else $error("job left the queue before its last cycle");
`endif

endmodule

// ----- rtl/nor_flash_command_sequencer.sv -----
// Top level of the parallel NOR flash command sequencer.
//
//   channel   dir  handshake          carries
//   in_cmd    in   valid / ready      kind, address, data (command or read data)
//   out_res   out  valid / ready      cycle_kind, bus_address, bus_data, status,
//                                     part_id, size_code, last
//
// One result leaves per clock while out_res is ready; a command expands into
// 1 to 7 results (identify 4, erase 7, program 5, poll read 1, identify
// finish 2, plain finish 1).
// The command port takes one transfer per clock while the job queue
// (QUEUE_DEPTH entries) has room; items that cause no result take no entry.
// Reset is synchronous and active low; it clears the phase tracking, the
// queue pointers and the output valid.
// A stalled out_res holds its result register and backs up the queue, which
// in turn drops in_cmd.ready when full.
module nor_flash_command_sequencer #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  nfcs_cmd_if.sink   in_cmd,
  nfcs_res_if.source out_res
);

  logic           push;
  logic           full;
  logic           pop;
  nfcs_pkg::job_t job;
  nfcs_pkg::q2b_t head;

  // classify each transfer and track the command phase
  nfcs_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (in_cmd),
    .full_i (full),
    .push_o (push),
    .job_o  (job)
  );

  // decouple the front end from the bus cycle sequencer
  nfcs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_i (push),
    .job_i  (job),
    .full_o (full),
    .head_o (head),
    .pop_i  (pop)
  );

  // expand jobs into unlock writes, command writes, reads and finishes
  nfcs_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head_i (head),
    .pop_o  (pop),
    .res    (out_res)
  );

endmodule
